>>> hw/rtl/glos_pkg.sv
// Shared constants, types and helpers for the grid line-of-sight block.
`default_nettype none
package glos_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Input coordinates are 8-bit signed; one more bit holds a neighbor offset.
  localparam int COORD_W = 8;
  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int DIST_W = 8;
  localparam int ERR_W = 12;

  localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_LOS = 2'd1;
  localparam logic [1:0] CMD_NEIGH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

  typedef struct packed {
    logic load;
    logic advance;
  } step_ctrl_t;

  // True when a sign-extended coordinate lies in 0 .. lim-1.
  function automatic logic coord_in(input logic [COORD_W:0] v, input logic [CFG_W-1:0] lim);
    return !v[COORD_W] && (v[COORD_W-1:0] < {1'b0, lim});
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/glos_ram.sv
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module glos_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/glos_line_step.sv
// Bresenham line stepper: produces one cell of the line per advance.
`default_nettype none
module glos_line_step #(
  parameter int MAX_ROWS = glos_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = glos_pkg::DEF_MAX_COLS
) (
  input  wire logic                        clk,
  input  wire glos_pkg::step_ctrl_t        ctrl,
  input  wire logic [$clog2(MAX_ROWS)-1:0] a_row,
  input  wire logic [$clog2(MAX_COLS)-1:0] a_col,
  input  wire logic [$clog2(MAX_ROWS)-1:0] b_row,
  input  wire logic [$clog2(MAX_COLS)-1:0] b_col,
  output logic      [$clog2(MAX_ROWS)-1:0] row,
  output logic      [$clog2(MAX_COLS)-1:0] col,
  output logic                             last
);

  localparam int DW = glos_pkg::DIST_W + 1;
  localparam int EW = glos_pkg::ERR_W;

  logic [DW-1:0]                 d_row, d_col, n_row, n_col;
  logic [glos_pkg::DIST_W-1:0]   abs_row, abs_col, big_in, small_in;
  logic [glos_pkg::DIST_W-1:0]   big, minor_len, cnt;
  logic                          major_row_in, major_row, row_neg, col_neg;
  logic [EW-1:0]                 err, err0, big2, small2;
  logic                          minor_step;

  assign d_row = DW'(b_row) - DW'(a_row);
  assign d_col = DW'(b_col) - DW'(a_col);
  assign n_row = d_row[DW-1] ? (~d_row + 1'b1) : d_row;
  assign n_col = d_col[DW-1] ? (~d_col + 1'b1) : d_col;
  assign abs_row = n_row[glos_pkg::DIST_W-1:0];
  assign abs_col = n_col[glos_pkg::DIST_W-1:0];

  // The row axis is major only when it is strictly longer.
  assign major_row_in = abs_row > abs_col;
  assign big_in = major_row_in ? abs_row : abs_col;
  assign small_in = major_row_in ? abs_col : abs_row;
  assign err0 = EW'(big_in) - (EW'(small_in) << 1);

  assign big2 = EW'(big) << 1;
  assign small2 = EW'(minor_len) << 1;
  // The minor axis moves when the midpoint error is zero or negative.
  assign minor_step = err[EW-1] || (err == '0);
  assign last = (cnt == '0);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      row <= a_row;
      col <= a_col;
      big <= big_in;
      minor_len <= small_in;
      cnt <= big_in;
      err <= err0;
      major_row <= major_row_in;
      row_neg <= d_row[DW-1];
      col_neg <= d_col[DW-1];
    end else if (ctrl.advance) begin
      err <= err + (minor_step ? big2 : '0) - small2;
      cnt <= cnt - 1'b1;
      if (major_row || minor_step) begin
        row <= row_neg ? row - 1'b1 : row + 1'b1;
      end
      if (!major_row || minor_step) begin
        col <= col_neg ? col - 1'b1 : col + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/grid_line_of_sight.sv
// Top level of the grid line-of-sight block: control sequencer and result register.
`default_nettype none
// The wall map is held in a RAM of MAX_ROWS rows of MAX_COLS bits, and every
// command is served one at a time through its single read port, one row per
// cycle. After reset the block clears the map row by row and stalls its input
// until that pass is done; configuration writes are taken at any time. A cell
// write reads the row and writes it back, a neighbor query reads three rows,
// and a line-of-sight query walks the line one cell, that is one row read, per
// cycle; a line-of-sight query with an endpoint outside the grid or a write
// outside it skips the walk or the write-back, and an unused command goes
// straight to the result. The next item is taken in the cycle after a result
// enters the output register, even while that result waits.
module grid_line_of_sight #(
  parameter int MAX_ROWS = glos_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = glos_pkg::DEF_MAX_COLS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [glos_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [glos_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      cmd,
  input  wire logic [glos_pkg::COORD_W-1:0]    a_row,
  input  wire logic [glos_pkg::COORD_W-1:0]    a_col,
  input  wire logic [glos_pkg::COORD_W-1:0]    b_row,
  input  wire logic [glos_pkg::COORD_W-1:0]    b_col,
  input  wire logic                            wall_bit,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 clear_line,
  output logic [8:0]                           neighbour_mask,
  output logic                                 point_inside
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int XW = glos_pkg::COORD_W + 1;
  localparam logic [glos_pkg::CFG_W-1:0] ROW_LIM = MAX_ROWS[glos_pkg::CFG_W-1:0];
  localparam logic [glos_pkg::CFG_W-1:0] COL_LIM = MAX_COLS[glos_pkg::CFG_W-1:0];
  localparam logic [RW-1:0] LAST_ROW = RW'(MAX_ROWS - 1);

  typedef enum logic [8:0] {
    S_CLEAR     = 9'b000000001,
    S_IDLE      = 9'b000000010,
    S_WR_RD     = 9'b000000100,
    S_WR_WR     = 9'b000001000,
    S_LOS_START = 9'b000010000,
    S_LOS_WALK  = 9'b000100000,
    S_NB_ISSUE  = 9'b001000000,
    S_DRAIN     = 9'b010000000,
    S_FINISH    = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [glos_pkg::CFG_W-1:0]   grid_rows, grid_cols, eff_rows, eff_cols;
  logic [1:0]                   cmd_q;
  logic [glos_pkg::COORD_W-1:0] a_row_q, a_col_q, b_row_q, b_col_q;
  logic                         wall_q;
  logic                         a_in, b_in;
  logic [RW-1:0]                clr_row;
  logic [1:0]                   nb_k, pend_k;
  logic                         pend;
  logic [CW-1:0]                col_q;
  logic                         blocked;
  logic [8:0]                   mask;
  logic [XW-1:0]                nb_row;
  logic                         nb_row_in;
  logic [XW-1:0]                nb_col [3];
  logic [2:0]                   nb_col_in;
  logic                         accept, finish_go;

  logic                ram_we;
  logic [RW-1:0]       ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata, ram_rdata, wr_row;

  glos_pkg::step_ctrl_t step_ctrl;
  logic [RW-1:0]        step_row;
  logic [CW-1:0]        step_col;
  logic                 step_last;

  // Configuration registers; sizes above the map saturate.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= glos_pkg::GRID_RESET;
      grid_cols <= glos_pkg::GRID_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        glos_pkg::REG_GRID_ROWS: grid_rows <= cfg_data;
        glos_pkg::REG_GRID_COLS: grid_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_rows = (grid_rows > ROW_LIM) ? ROW_LIM : grid_rows;
  assign eff_cols = (grid_cols > COL_LIM) ? COL_LIM : grid_cols;

  assign a_in = glos_pkg::coord_in({a_row_q[glos_pkg::COORD_W-1], a_row_q}, eff_rows) &&
                glos_pkg::coord_in({a_col_q[glos_pkg::COORD_W-1], a_col_q}, eff_cols);
  assign b_in = glos_pkg::coord_in({b_row_q[glos_pkg::COORD_W-1], b_row_q}, eff_rows) &&
                glos_pkg::coord_in({b_col_q[glos_pkg::COORD_W-1], b_col_q}, eff_cols);

  // Neighbor window: row offset nb_k - 1, columns at offsets -1, 0, +1.
  assign nb_row = {a_row_q[glos_pkg::COORD_W-1], a_row_q} + XW'(nb_k) - XW'(1);
  assign nb_row_in = glos_pkg::coord_in(nb_row, eff_rows);

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      nb_col[d] = {a_col_q[glos_pkg::COORD_W-1], a_col_q} + XW'(d) - XW'(1);
      nb_col_in[d] = glos_pkg::coord_in(nb_col[d], eff_cols);
    end
  end

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign finish_go = (state == S_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_row == LAST_ROW) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            glos_pkg::CMD_WRITE: state_next = S_WR_RD;
            glos_pkg::CMD_LOS:   state_next = S_LOS_START;
            glos_pkg::CMD_NEIGH: state_next = S_NB_ISSUE;
            default:             state_next = S_FINISH;
          endcase
        end
      end
      S_WR_RD:     state_next = a_in ? S_WR_WR : S_FINISH;
      S_WR_WR:     state_next = S_FINISH;
      S_LOS_START: state_next = (a_in && b_in) ? S_LOS_WALK : S_FINISH;
      S_LOS_WALK: begin
        if (step_last) state_next = S_DRAIN;
      end
      S_NB_ISSUE: begin
        if (nb_k == 2'd2) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_FINISH;
      S_FINISH: begin
        if (finish_go) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign step_ctrl.load = (state == S_LOS_START) && a_in && b_in;
  assign step_ctrl.advance = (state == S_LOS_WALK);

  glos_line_step #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_step (
    .clk  (clk),
    .ctrl (step_ctrl),
    .a_row(a_row_q[RW-1:0]),
    .a_col(a_col_q[CW-1:0]),
    .b_row(b_row_q[RW-1:0]),
    .b_col(b_col_q[CW-1:0]),
    .row  (step_row),
    .col  (step_col),
    .last (step_last)
  );

  always_comb begin
    wr_row = ram_rdata;
    wr_row[a_col_q[CW-1:0]] = wall_q;
  end

  // A cell write reads its row and writes it back in the next cycle; no other
  // access runs in between, so no forwarding is needed.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = clr_row;
    ram_wdata = '0;
    ram_raddr = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_WR_WR) begin
      ram_we = 1'b1;
      ram_waddr = a_row_q[RW-1:0];
      ram_wdata = wr_row;
    end
    priority if (state == S_WR_RD) begin
      ram_raddr = a_row_q[RW-1:0];
    end else if (state == S_LOS_WALK) begin
      ram_raddr = step_row;
    end else if (state == S_NB_ISSUE) begin
      ram_raddr = nb_row[RW-1:0];
    end else begin
      ram_raddr = '0;
    end
  end

  glos_ram #(
    .WIDTH(MAX_COLS),
    .DEPTH(MAX_ROWS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_row <= '0;
      pend <= 1'b0;
      nb_k <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_row <= clr_row + 1'b1;
      pend <= ((state == S_LOS_WALK) || ((state == S_NB_ISSUE) && nb_row_in));
      if (state == S_NB_ISSUE) begin
        nb_k <= nb_k + 1'b1;
      end else begin
        nb_k <= '0;
      end
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item fields, walk bookkeeping and the result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      a_row_q <= a_row;
      a_col_q <= a_col;
      b_row_q <= b_row;
      b_col_q <= b_col;
      wall_q <= wall_bit;
      blocked <= 1'b0;
      mask <= '0;
    end else begin
      if ((state == S_LOS_START) && !(a_in && b_in)) blocked <= 1'b1;
      // Row data arrives in the cycle after its address was issued.
      if (pend) begin
        if (cmd_q == glos_pkg::CMD_LOS) begin
          blocked <= blocked | ram_rdata[col_q];
        end else begin
          for (int k = 0; k < 3; k++) begin
            for (int d = 0; d < 3; d++) begin
              if (pend_k == 2'(k)) begin
                mask[3*k+d] <= nb_col_in[d] && !ram_rdata[nb_col[d][CW-1:0]];
              end
            end
          end
        end
      end
    end
    col_q <= step_col;
    pend_k <= nb_k;
    if (finish_go) begin
      clear_line <= (cmd_q == glos_pkg::CMD_LOS) && !blocked;
      neighbour_mask <= ((cmd_q == glos_pkg::CMD_NEIGH) && a_in) ? mask : '0;
      point_inside <= a_in;
    end
  end

endmodule
`default_nettype wire
